/* src/pmo_pkg.sv */
// Package for the polyline miter offset block: payload words, widths and constants.
// Used by polyline_miter_offset and pmo_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pmo_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int COORD_FRAC_DEF  = 16;
    // magnitude of a coordinate difference, also wide enough for a [2^29, 2^30) window
    localparam int MAG_W           = (COORD_WIDTH + 1 > 30) ? COORD_WIDTH + 1 : 30;
    localparam int HW_W            = 24;
    localparam int SCALE_W         = 47;
    localparam int CFG_DATA_W      = 47;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE    = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 47'h4000_0000_0000;

    // 0.97 with 32 fraction bits
    localparam logic signed [35:0] DOT_LIMIT = 36'sd4166118278;
    localparam logic signed [35:0] DOT_ONE   = 36'sd4294967296;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic                          final_vertex;
    } t_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] offset_x;
        logic signed [COORD_WIDTH-1:0] offset_y;
        logic                          end_of_line;
    } t_out;

endpackage

`default_nettype wire

/* src/polyline_miter_offset.sv */
// Polyline miter offset: left-edge offset vector for each vertex of a polyline.
// Depends on pmo_pkg for payload words, widths and constants.
`timescale 1ns / 1ps
`default_nettype none

// Vertices enter one word at a time; each vertex's left-edge offset leaves one vertex later,
// so the final vertex of a line yields two words (the second flagged end_of_line) and a
// one-point line yields a single zero word. Segment normals and the corner bisector are
// normalised by one shared iterative unit (one root bit or one quotient bit per cycle),
// and one registered 32x32 multiplier builds the squared magnitudes, the dot product, the
// half-width product, the widening and the axis scaling from partial products. A first
// vertex that is not final is only held; an inner vertex is worked through two
// normalisations (shift search, 32-step square root, two 18-step divides each) and, for a
// widened corner, the 47-step divide plus 24-step root of the miter factor. The input is
// not ready while a vertex is being worked; a finished word waits in the output register
// meanwhile. Configuration writes (half width, per-axis reciprocal scales) take effect at
// once and are expected only while the block is idle.
module polyline_miter_offset #(
    parameter int COORD_FRAC_BITS = pmo_pkg::COORD_FRAC_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  pmo_pkg::t_in                       i_in,
    output logic                               o_valid,
    input  wire                                i_ready,
    output pmo_pkg::t_out                      o_out,
    input  wire                                i_cfg_we,
    input  wire  [pmo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [pmo_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW = pmo_pkg::COORD_WIDTH;
    localparam int NW = pmo_pkg::MAG_W;
    localparam int SH = 78 - COORD_FRAC_BITS;
    localparam logic [95:0]   RND_SC = 96'(1) << (SH - 1);
    localparam logic [95:0]   RND_W  = 96'(1) << 19;
    localparam logic [NW-1:0] M_HI   = NW'(1) << 30;
    localparam logic [NW-1:0] M_LO   = NW'(1) << 29;
    localparam logic [CW-1:0] LIM    = CW'(1) << (CW - 1);

    typedef enum logic [5:0] {
        S_IDLE, S_NSHIFT, S_SQ0, S_SQ1, S_SQ2, S_NSQRT, S_NDX, S_NDIV, S_NDY, S_NFIN,
        S_NRET, S_DOT0, S_DOT1, S_DOT2, S_DOT3, S_WLD, S_WDIV, S_WSQLD, S_WSQRT, S_WEND,
        S_E0, S_E1, S_EW0, S_EW1, S_EW2, S_EW3, S_ES0, S_ES1, S_ES2, S_ES3, S_ES4,
        S_ESAT, S_EOUT
    } t_state;

    typedef enum logic [1:0] {PH_NONE, PH_FIRST, PH_INNER} t_phase;
    typedef enum logic [1:0] {EK_SOLO, EK_MAIN, EK_LAST} t_ekind;
    typedef enum logic {NS_SEG, NS_BIS} t_nsel;

    function automatic logic [16:0] mag18(input logic signed [17:0] v);
        mag18 = v[17] ? 17'(-v) : 17'(v);
    endfunction

    function automatic logic [17:0] mag19(input logic signed [18:0] v);
        mag19 = v[18] ? 18'(-v) : 18'(v);
    endfunction

    function automatic logic signed [17:0] apply_sign(input logic neg, input logic [16:0] m);
        apply_sign = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    t_state r_state;
    t_phase r_phase;
    t_ekind r_ekind;
    t_nsel  r_nsel;

    logic [pmo_pkg::HW_W-1:0]    r_half_width;
    logic [pmo_pkg::SCALE_W-1:0] r_xs, r_ys;

    logic signed [CW-1:0] r_held_x, r_held_y, r_cx, r_cy;
    logic                 r_fin;
    logic signed [17:0]   r_pnx, r_pny, r_nx, r_ny, r_rx, r_ry, r_ecx, r_ecy;
    logic                 r_xneg, r_yneg;
    logic [NW-1:0]        r_mx, r_my;
    logic [30:0]          r_q;
    logic                 r_divy;
    logic signed [35:0]   r_dot;
    logic                 r_widen, r_ewiden;
    logic [23:0]          r_w;
    logic [73:0]          r_ux;
    logic [63:0]          r_ur;
    logic [33:0]          r_urem, r_udiv;
    logic [5:0]           r_cnt;
    logic [63:0]          r_prod;
    logic [95:0]          r_acc;
    logic [43:0]          r_t;
    logic                 r_axis;
    logic [CW-1:0]        r_res_x, r_res_y;
    logic                 r_ovalid;
    pmo_pkg::t_out        r_out;

    // segment from the held vertex to the incoming one
    logic signed [CW:0] dx_s, dy_s;
    logic               dx_neg, dy_neg;
    logic [CW:0]        dx_mag, dy_mag;
    // bisector of the two normals
    logic signed [18:0] sx_s, sy_s;
    // shared root / divide step
    logic [63:0]        sq_bit, sq_sum;
    logic               sq_ge;
    logic [34:0]        dv_rem2;
    logic               dv_ge;
    logic [34:0]        dv_diff;
    // normalisation window and divide operands
    logic [NW-1:0]      m_max;
    logic [46:0]        dvd_x, dvd_y;
    // multiplier operands
    logic [31:0]        ma, mb;
    // axis being emitted
    logic signed [17:0] comp;
    logic               cneg;
    logic [16:0]        cmag;
    logic [pmo_pkg::SCALE_W-1:0] scale;
    logic signed [35:0] term;
    logic signed [35:0] u_s;
    logic [95:0]        sat_mag;
    logic [CW-1:0]      sat_abs, sat_res;
    logic               out_free;

    assign dx_s   = $signed({i_in.point_x[CW-1], i_in.point_x})
                  - $signed({r_held_x[CW-1], r_held_x});
    assign dy_s   = $signed({i_in.point_y[CW-1], i_in.point_y})
                  - $signed({r_held_y[CW-1], r_held_y});
    assign dx_neg = dx_s[CW];
    assign dy_neg = dy_s[CW];
    assign dx_mag = dx_neg ? (~dx_s) + 1'b1 : dx_s;
    assign dy_mag = dy_neg ? (~dy_s) + 1'b1 : dy_s;

    assign sx_s = $signed({r_nx[17], r_nx}) + $signed({r_pnx[17], r_pnx});
    assign sy_s = $signed({r_ny[17], r_ny}) + $signed({r_pny[17], r_pny});

    assign sq_bit  = 64'(1) << {r_cnt[4:0], 1'b0};
    assign sq_sum  = r_ur + sq_bit;
    assign sq_ge   = r_ux[63:0] >= sq_sum;
    assign dv_rem2 = {r_urem, r_ux[73]};
    assign dv_ge   = dv_rem2 >= {1'b0, r_udiv};
    assign dv_diff = dv_rem2 - {1'b0, r_udiv};

    assign m_max = (r_mx > r_my) ? r_mx : r_my;
    assign dvd_x = (47'(r_mx[29:0]) << 16) + 47'(r_ur[30:1]);
    assign dvd_y = (47'(r_my[29:0]) << 16) + 47'(r_q[30:1]);

    assign comp  = r_axis ? r_ecy : r_ecx;
    assign cneg  = comp[17];
    assign cmag  = mag18(comp);
    assign scale = r_axis ? r_ys : r_xs;
    assign term  = $signed({3'b0, r_prod[32:0]});
    assign u_s   = pmo_pkg::DOT_ONE - r_dot;

    assign sat_mag = r_acc >> SH;
    always_comb begin
        if (cneg) begin
            sat_abs = (sat_mag > 96'(LIM)) ? LIM : sat_mag[CW-1:0];
            sat_res = (~sat_abs) + 1'b1;
        end else begin
            sat_abs = (sat_mag > 96'(LIM - 1'b1)) ? LIM - 1'b1 : sat_mag[CW-1:0];
            sat_res = sat_abs;
        end
    end

    // operand select for the one shared multiplier
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (r_state)
            S_SQ0: begin ma = 32'(r_mx[29:0]); mb = 32'(r_mx[29:0]); end
            S_SQ1: begin ma = 32'(r_my[29:0]); mb = 32'(r_my[29:0]); end
            S_DOT0: begin ma = 32'(mag18(r_pnx)); mb = 32'(mag18(r_nx)); end
            S_DOT1: begin ma = 32'(mag18(r_pny)); mb = 32'(mag18(r_ny)); end
            S_E0: begin ma = 32'(cmag); mb = 32'(r_half_width); end
            S_EW0: begin ma = r_t[31:0]; mb = 32'(r_w); end
            S_EW1: begin ma = 32'(r_t[43:32]); mb = 32'(r_w); end
            S_ES0: begin ma = r_t[31:0]; mb = scale[31:0]; end
            S_ES1: begin ma = r_t[31:0]; mb = 32'(scale[46:32]); end
            S_ES2: begin ma = 32'(r_t[43:32]); mb = scale[31:0]; end
            S_ES3: begin ma = 32'(r_t[43:32]); mb = 32'(scale[46:32]); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_out    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_NONE;
            r_ovalid     <= 1'b0;
            r_half_width <= '0;
            r_xs         <= pmo_pkg::SCALE_RESET;
            r_ys         <= pmo_pkg::SCALE_RESET;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_pnx        <= '0;
            r_pny        <= '0;
        end else begin
            r_prod <= 64'(ma) * 64'(mb);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pmo_pkg::CFG_HALF_WIDTH: r_half_width <= i_cfg_data[pmo_pkg::HW_W-1:0];
                    pmo_pkg::CFG_X_SCALE:    r_xs <= i_cfg_data[pmo_pkg::SCALE_W-1:0];
                    pmo_pkg::CFG_Y_SCALE:    r_ys <= i_cfg_data[pmo_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cx  <= i_in.point_x;
                        r_cy  <= i_in.point_y;
                        r_fin <= i_in.final_vertex;
                        if (r_phase == PH_NONE) begin
                            if (i_in.final_vertex) begin
                                // one-point line: a zero offset closes it
                                r_ecx    <= '0;
                                r_ecy    <= '0;
                                r_ewiden <= 1'b0;
                                r_ekind  <= EK_SOLO;
                                r_axis   <= 1'b0;
                                r_state  <= S_E0;
                            end else begin
                                r_held_x <= i_in.point_x;
                                r_held_y <= i_in.point_y;
                                r_phase  <= PH_FIRST;
                            end
                        end else begin
                            // left normal is (-dy, dx)
                            r_mx    <= NW'(dy_mag);
                            r_xneg  <= !dy_neg;
                            r_my    <= NW'(dx_mag);
                            r_yneg  <= dx_neg;
                            r_nsel  <= NS_SEG;
                            r_state <= S_NSHIFT;
                        end
                    end
                end
                S_NSHIFT: begin
                    priority if (m_max == '0) begin
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_state <= S_NRET;
                    end else if (m_max >= M_HI) begin
                        r_mx <= r_mx >> 1;
                        r_my <= r_my >> 1;
                    end else if (m_max < M_LO) begin
                        r_mx <= r_mx << 1;
                        r_my <= r_my << 1;
                    end else begin
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0: r_state <= S_SQ1;
                S_SQ1: begin
                    r_acc   <= 96'(r_prod);
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_ux    <= 74'(r_acc[63:0] + r_prod);
                    r_ur    <= '0;
                    r_cnt   <= 6'd31;
                    r_state <= S_NSQRT;
                end
                S_NSQRT, S_WSQRT: begin
                    if (sq_ge) begin
                        r_ux[63:0] <= r_ux[63:0] - sq_sum;
                        r_ur       <= (r_ur >> 1) + sq_bit;
                    end else begin
                        r_ur <= r_ur >> 1;
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= (r_state == S_NSQRT) ? S_NDX : S_WEND;
                    end
                end
                S_NDX: begin
                    // quotient fits 18 bits, so its upper dividend bits preload the remainder
                    r_q     <= r_ur[30:0];
                    r_udiv  <= 34'(r_ur[30:0]);
                    r_urem  <= 34'(dvd_x[46:18]);
                    r_ux    <= {dvd_x[17:0], 56'b0};
                    r_ur    <= '0;
                    r_cnt   <= 6'd17;
                    r_divy  <= 1'b0;
                    r_state <= S_NDIV;
                end
                S_NDIV, S_WDIV: begin
                    r_urem <= dv_ge ? dv_diff[33:0] : dv_rem2[33:0];
                    r_ux   <= r_ux << 1;
                    r_ur   <= {r_ur[62:0], dv_ge};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        if (r_state == S_WDIV) begin
                            r_state <= S_WSQLD;
                        end else begin
                            r_state <= r_divy ? S_NFIN : S_NDY;
                        end
                    end
                end
                S_NDY: begin
                    r_rx    <= apply_sign(r_xneg, r_ur[16:0]);
                    r_udiv  <= 34'(r_q);
                    r_urem  <= 34'(dvd_y[46:18]);
                    r_ux    <= {dvd_y[17:0], 56'b0};
                    r_ur    <= '0;
                    r_cnt   <= 6'd17;
                    r_divy  <= 1'b1;
                    r_state <= S_NDIV;
                end
                S_NFIN: begin
                    r_ry    <= apply_sign(r_yneg, r_ur[16:0]);
                    r_state <= S_NRET;
                end
                S_NRET: begin
                    unique case (r_nsel)
                        NS_SEG: begin
                            r_nx <= r_rx;
                            r_ny <= r_ry;
                            if (r_phase == PH_FIRST) begin
                                r_ecx    <= r_rx;
                                r_ecy    <= r_ry;
                                r_ewiden <= 1'b0;
                                r_ekind  <= EK_MAIN;
                                r_axis   <= 1'b0;
                                r_state  <= S_E0;
                            end else begin
                                r_state <= S_DOT0;
                            end
                        end
                        NS_BIS: begin
                            if (r_widen) begin
                                r_state <= S_WLD;
                            end else begin
                                r_ecx    <= r_rx;
                                r_ecy    <= r_ry;
                                r_ewiden <= 1'b0;
                                r_ekind  <= EK_MAIN;
                                r_axis   <= 1'b0;
                                r_state  <= S_E0;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_DOT0: r_state <= S_DOT1;
                S_DOT1: begin
                    // dot is the negated sum of the products
                    r_dot   <= (r_pnx[17] ^ r_nx[17]) ? term : -term;
                    r_state <= S_DOT2;
                end
                S_DOT2: begin
                    r_dot   <= (r_pny[17] ^ r_ny[17]) ? r_dot + term : r_dot - term;
                    r_state <= S_DOT3;
                end
                S_DOT3: begin
                    r_widen <= (r_dot > -pmo_pkg::DOT_LIMIT) && (r_dot < pmo_pkg::DOT_LIMIT);
                    r_mx    <= NW'(mag19(sx_s));
                    r_xneg  <= sx_s[18];
                    r_my    <= NW'(mag19(sy_s));
                    r_yneg  <= sy_s[18];
                    r_nsel  <= NS_BIS;
                    r_state <= S_NSHIFT;
                end
                S_WLD: begin
                    // 2^73 / u: quotient under 2^47, so 2^26 seeds the remainder
                    r_udiv  <= u_s[33:0];
                    r_urem  <= 34'(1) << 26;
                    r_ux    <= '0;
                    r_ur    <= '0;
                    r_cnt   <= 6'd46;
                    r_state <= S_WDIV;
                end
                S_WSQLD: begin
                    r_ux    <= 74'(r_ur[46:0]);
                    r_ur    <= '0;
                    r_cnt   <= 6'd23;
                    r_state <= S_WSQRT;
                end
                S_WEND: begin
                    r_w      <= r_ur[23:0];
                    r_ecx    <= r_rx;
                    r_ecy    <= r_ry;
                    r_ewiden <= 1'b1;
                    r_ekind  <= EK_MAIN;
                    r_axis   <= 1'b0;
                    r_state  <= S_E0;
                end
                S_E0: r_state <= S_E1;
                S_E1: begin
                    r_t     <= r_prod[43:0];
                    r_state <= r_ewiden ? S_EW0 : S_ES0;
                end
                S_EW0: r_state <= S_EW1;
                S_EW1: begin
                    r_acc   <= 96'(r_prod) + RND_W;
                    r_state <= S_EW2;
                end
                S_EW2: begin
                    r_acc   <= r_acc + (96'(r_prod) << 32);
                    r_state <= S_EW3;
                end
                S_EW3: begin
                    r_t     <= r_acc[63:20];
                    r_state <= S_ES0;
                end
                S_ES0: begin
                    r_acc   <= RND_SC;
                    r_state <= S_ES1;
                end
                S_ES1: begin
                    r_acc   <= r_acc + 96'(r_prod);
                    r_state <= S_ES2;
                end
                S_ES2: begin
                    r_acc   <= r_acc + (96'(r_prod) << 32);
                    r_state <= S_ES3;
                end
                S_ES3: begin
                    r_acc   <= r_acc + (96'(r_prod) << 32);
                    r_state <= S_ES4;
                end
                S_ES4: begin
                    r_acc   <= r_acc + (96'(r_prod) << 64);
                    r_state <= S_ESAT;
                end
                S_ESAT: begin
                    if (r_axis) begin
                        r_res_y <= sat_res;
                        r_state <= S_EOUT;
                    end else begin
                        r_res_x <= sat_res;
                        r_axis  <= 1'b1;
                        r_state <= S_E0;
                    end
                end
                S_EOUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_ovalid          <= 1'b1;
                        r_out.offset_x    <= r_res_x;
                        r_out.offset_y    <= r_res_y;
                        r_out.end_of_line <= (r_ekind != EK_MAIN);
                        unique case (r_ekind)
                            EK_SOLO: r_state <= S_IDLE;
                            EK_MAIN: begin
                                if (r_fin) begin
                                    // last vertex: its own segment normal, unwidened
                                    r_ecx    <= r_nx;
                                    r_ecy    <= r_ny;
                                    r_ewiden <= 1'b0;
                                    r_ekind  <= EK_LAST;
                                    r_axis   <= 1'b0;
                                    r_state  <= S_E0;
                                end else begin
                                    r_pnx    <= r_nx;
                                    r_pny    <= r_ny;
                                    r_held_x <= r_cx;
                                    r_held_y <= r_cy;
                                    r_phase  <= PH_INNER;
                                    r_state  <= S_IDLE;
                                end
                            end
                            EK_LAST: begin
                                r_phase <= PH_NONE;
                                r_state <= S_IDLE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/pmo_checker.sv */
// Port-level checks for polyline_miter_offset, bound to every instance of it.
// Depends on pmo_pkg for the payload word types.
`timescale 1ns / 1ps
`default_nettype none

module pmo_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_valid,
    input wire                            o_ready,
    input pmo_pkg::t_in                   i_in,
    input wire                            o_valid,
    input wire                            i_ready,
    input pmo_pkg::t_out                  o_out,
    input wire                            i_cfg_we,
    input wire [pmo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input wire [pmo_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // a waiting word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("output word changed or dropped while stalled");

    // a fresh word is only produced while the block is busy with a vertex
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("output word appeared while the input side was idle");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind polyline_miter_offset pmo_checker u_pmo_checker (.*);

`default_nettype wire
